// ----- hdl/integer_alu_fold_macros.svh -----
// Assertion macros used by the checker file.
`ifndef INTEGER_ALU_FOLD_MACROS_SVH
`define INTEGER_ALU_FOLD_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IAF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same check, also active during reset.
`define IAF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- hdl/iaf_pkg.sv -----
// Package: payload types, operation codes and shared constants.
`default_nettype none
package iaf_pkg;
   localparam int unsigned WordWidth = 64;
   localparam int unsigned OpWidth = 5;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueIdxWidth = 2;
   // Back-end pipeline: 64 divide stages plus setup and finish stages.
   localparam int unsigned DivSteps = 64;
   localparam int unsigned PipeDepth = DivSteps + 2;

   localparam logic [OpWidth-1:0] OP_ADD = 5'd0;
   localparam logic [OpWidth-1:0] OP_SUB = 5'd1;
   localparam logic [OpWidth-1:0] OP_MUL = 5'd2;
   localparam logic [OpWidth-1:0] OP_DIV = 5'd3;
   localparam logic [OpWidth-1:0] OP_MOD = 5'd4;
   localparam logic [OpWidth-1:0] OP_AND = 5'd5;
   localparam logic [OpWidth-1:0] OP_OR  = 5'd6;
   localparam logic [OpWidth-1:0] OP_XOR = 5'd7;
   localparam logic [OpWidth-1:0] OP_SHL = 5'd8;
   localparam logic [OpWidth-1:0] OP_SHR = 5'd9;
   localparam logic [OpWidth-1:0] OP_LT  = 5'd10;
   localparam logic [OpWidth-1:0] OP_LE  = 5'd11;
   localparam logic [OpWidth-1:0] OP_GT  = 5'd12;
   localparam logic [OpWidth-1:0] OP_GE  = 5'd13;
   localparam logic [OpWidth-1:0] OP_EQ  = 5'd14;
   localparam logic [OpWidth-1:0] OP_NE  = 5'd15;

   typedef struct packed {
      logic [OpWidth-1:0]          operation;
      logic signed [WordWidth-1:0] left_value;
      logic signed [WordWidth-1:0] right_value;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] fold_result;
      logic                        folded;
   } rsp_type;

   // Unit classes decided in the front end.
   typedef enum logic [2:0] {
      CLS_ARITH, CLS_MUL, CLS_DIV, CLS_MOD, CLS_LOGIC, CLS_SHIFT, CLS_CMP, CLS_NONE
   } cls_type;

   typedef struct packed {
      cls_type                     cls;
      logic [OpWidth-1:0]          operation;
      logic [WordWidth-1:0]        left_value;
      logic [WordWidth-1:0]        right_value;
   } work_type;
endpackage
`default_nettype wire

// ----- hdl/integer_alu_fold.sv -----
// Top level of the 64-bit integer fold unit.
// Usage:
//   req channel (valid/ready) carries one item: operation, left, right.
//   rsp channel (valid/ready) returns one item per request, in order:
//   fold_result and folded.
// Structure: a front end classifies each item into a 4-entry queue; the
//   back end is a 66-stage pipeline (setup, 64 restoring divide steps,
//   finish) feeding an output register.
// Throughput: one item per cycle unless stalled; the divider pipeline sets
//   the latency and the output register plus queue decouple the two sides.
// Stall: when rsp is held and the output register is full the whole back
//   end freezes; the queue then fills, and req_ready drops at four entries.
// Reset: synchronous, clears the queue pointers, pipeline valid bits and
//   the output valid; no item is in flight afterward.
// Zero divisor or an unknown operation code gives folded 0 and result 0.
`default_nettype none
module integer_alu_fold (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire iaf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output iaf_pkg::rsp_type      rsp_data
);
   import iaf_pkg::*;

   work_type work_data;
   rsp_type  done_data;
   rsp_type  out_ff;
   logic     out_v_ff, out_v_in;
   logic     work_valid, done_valid, enable;

   // Pipeline advances whenever the output register can take its tail.
   assign enable = !out_v_ff || rsp_ready;

   iaf_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .work_valid, .work_ready(enable), .work_data
   );

   iaf_back u_back (
      .clock, .reset, .enable, .work_valid, .work_data,
      .done_valid, .done_data
   );

   assign out_v_in = enable ? done_valid : out_v_ff;

   always_ff @(posedge clock) begin
      if (enable) out_ff <= done_data;
      if (reset) out_v_ff <= 1'b0;
      else       out_v_ff <= out_v_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;
endmodule
`default_nettype wire

// ----- hdl/iaf_front.sv -----
// Front end: accepts items, classifies the operation, writes the work queue.
`default_nettype none
module iaf_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire iaf_pkg::req_type req_data,
   output logic                  work_valid,
   input  wire logic             work_ready,
   output iaf_pkg::work_type     work_data
);
   import iaf_pkg::*;

   work_type                  mem [QueueDepth];
   logic [QueueIdxWidth:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueIdxWidth:0]    fill;
   cls_type                   cls;
   logic                      push, pop;

   always_comb begin
      unique case (req_data.operation) inside
         OP_ADD, OP_SUB:                 cls = CLS_ARITH;
         OP_MUL:                         cls = CLS_MUL;
         OP_DIV:                         cls = CLS_DIV;
         OP_MOD:                         cls = CLS_MOD;
         OP_AND, OP_OR, OP_XOR:          cls = CLS_LOGIC;
         OP_SHL, OP_SHR:                 cls = CLS_SHIFT;
         [OP_LT:OP_NE]:                  cls = CLS_CMP;
         default:                        cls = CLS_NONE;
      endcase
   end

   assign fill = wr_ff - rd_ff;
   assign req_ready = (fill != (QueueIdxWidth+1)'(QueueDepth));
   assign work_valid = (fill != '0);
   assign push = req_valid && req_ready;
   assign pop = work_valid && work_ready;
   assign work_data = mem[rd_ff[QueueIdxWidth-1:0]];
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff[QueueIdxWidth-1:0]] <= '{cls, req_data.operation,
                                            req_data.left_value, req_data.right_value};
      end
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/iaf_back.sv -----
// Back end: pipelined execute with a restoring divider, one radix-2 step a stage.
`default_nettype none
module iaf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              work_valid,
   input  wire iaf_pkg::work_type work_data,
   output logic                   done_valid,
   output iaf_pkg::rsp_type       done_data
);
   import iaf_pkg::*;

   typedef struct packed {
      cls_type              cls;
      logic [WordWidth-1:0] res;     // result for non-divide ops
      logic                 ok;
      logic                 neg_q;
      logic                 neg_r;
      logic [WordWidth-1:0] rem;
      logic [WordWidth-1:0] quo;     // dividend shifting out, quotient shifting in
      logic [WordWidth-1:0] dvs;
   } stage_type;

   // Multiplier: 3 partial products of 32x32 registered in setup stage.
   logic [WordWidth-1:0] pp_ll_ff, pp_lh_ff, pp_hl_ff;
   logic                 v_ff [PipeDepth];
   stage_type            st_ff [PipeDepth];
   stage_type            s0;
   stage_type            s1;
   logic [WordWidth-1:0] a, b, ma, mb, shr_v;
   logic                 lt;

   always_comb begin
      a = work_data.left_value;
      b = work_data.right_value;
      ma = a[WordWidth-1] ? (~a + 1'b1) : a;
      mb = b[WordWidth-1] ? (~b + 1'b1) : b;
      lt = $signed(a) < $signed(b);
      shr_v = $unsigned($signed(a) >>> b[5:0]);
      s0 = '0;
      s0.cls = work_data.cls;
      s0.ok = 1'b1;
      s0.quo = ma;
      s0.dvs = mb;
      s0.neg_q = a[WordWidth-1] ^ b[WordWidth-1];
      s0.neg_r = a[WordWidth-1];
      case (work_data.operation)
         OP_ADD: s0.res = a + b;
         OP_SUB: s0.res = a - b;
         OP_AND: s0.res = a & b;
         OP_OR:  s0.res = a | b;
         OP_XOR: s0.res = a ^ b;
         OP_SHL: s0.res = a << b[5:0];
         OP_SHR: s0.res = shr_v;
         OP_LT:  s0.res = {63'd0, lt};
         OP_LE:  s0.res = {63'd0, !($signed(b) < $signed(a))};
         OP_GT:  s0.res = {63'd0, $signed(b) < $signed(a)};
         OP_GE:  s0.res = {63'd0, !lt};
         OP_EQ:  s0.res = {63'd0, a == b};
         OP_NE:  s0.res = {63'd0, a != b};
         default: s0.res = '0;
      endcase
      if (work_data.cls == CLS_NONE ||
          ((work_data.cls == CLS_DIV || work_data.cls == CLS_MOD) && b == '0)) begin
         s0.ok = 1'b0;
      end
   end

   // Divide step: shift one dividend bit into the partial remainder.
   function automatic stage_type div_step(input stage_type s);
      logic [WordWidth:0] trial;
      stage_type          o;
      o = s;
      trial = {s.rem, s.quo[WordWidth-1]} - {1'b0, s.dvs};
      if (!trial[WordWidth]) begin
         o.rem = trial[WordWidth-1:0];
         o.quo = {s.quo[WordWidth-2:0], 1'b1};
      end else begin
         o.rem = {s.rem[WordWidth-2:0], s.quo[WordWidth-1]};
         o.quo = {s.quo[WordWidth-2:0], 1'b0};
      end
      return o;
   endfunction

   // Stage 1 also folds the product; later ones divide, the finish stage copies.
   always_comb begin
      s1 = div_step(st_ff[0]);
      if (st_ff[0].cls == CLS_MUL) begin
         s1.res = pp_ll_ff + {pp_lh_ff[31:0] + pp_hl_ff[31:0], 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff[0] <= s0;
         pp_ll_ff <= a[31:0] * b[31:0];
         pp_lh_ff <= a[31:0] * b[63:32];
         pp_hl_ff <= a[63:32] * b[31:0];
         st_ff[1] <= s1;
         for (int i = 2; i < PipeDepth; i++) begin
            st_ff[i] <= (i <= DivSteps) ? div_step(st_ff[i-1]) : st_ff[i-1];
         end
      end
      if (reset) begin
         for (int i = 0; i < PipeDepth; i++) v_ff[i] <= 1'b0;
      end else if (enable) begin
         v_ff[0] <= work_valid;
         for (int i = 1; i < PipeDepth; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_comb begin
      stage_type t;
      logic [WordWidth-1:0] r;
      t = st_ff[PipeDepth-1];
      case (t.cls)
         CLS_DIV: r = t.neg_q ? (~t.quo + 1'b1) : t.quo;
         CLS_MOD: r = t.neg_r ? (~t.rem + 1'b1) : t.rem;
         default: r = t.res;
      endcase
      done_valid = v_ff[PipeDepth-1];
      done_data.folded = t.ok;
      done_data.fold_result = t.ok ? r : '0;
   end
endmodule
`default_nettype wire

// ----- hdl/iaf_checker.sv -----
// Port checker for the fold unit, bound to the top level.
`default_nettype none
`include "integer_alu_fold_macros.svh"
module iaf_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire iaf_pkg::rsp_type rsp_data
);
   import iaf_pkg::*;
   `IAF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp dropped while stalled")
   `IAF_ASSERT(a_zero_unfolded, clock, reset, rsp_valid && !rsp_data.folded |-> rsp_data.fold_result == '0, "unfolded result not zero")
   `IAF_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid && req_ready, "not empty after reset")
   `IAF_ASSERT(a_no_early_rsp, clock, reset, $past(reset) |=> !rsp_valid, "rsp too soon after reset")
endmodule

bind integer_alu_fold iaf_checker u_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire
